[rtl/plc_pkg.sv]
// ----------------------------------------------------------------------------
// plc_pkg: shared definitions for the piecewise linear calibration block
// Widths, register indexes, queue depths and the entry types that travel
// between the classify front end, the queues and the divide back end.
// ----------------------------------------------------------------------------
package plc_pkg;

  // Default module parameters
  localparam int MAX_SEGMENTS_DEF  = 7;
  localparam int FRACTION_BITS_DEF = 4;

  // Field widths
  localparam int VAL_W  = 16;  // signed Q11.4 value
  localparam int PIX_W  = 8;   // pixel byte
  localparam int CFG_W  = 48;  // widest register
  localparam int CNT_W  = 3;   // segment_count
  localparam int NUM_W  = 27;  // signed numerator of the segment formula
  localparam int ADR_W  = 16;  // magnitude of the segment width
  localparam int REM_W  = 24;  // divider remainder, numerator below 256 * width

  // Register map
  localparam int SEG_REGS  = 7;
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_0     = 3'd1;

  // Queue depths
  localparam int MID_DEPTH = 8;
  localparam int OUT_DEPTH = 16;

  // One calibration segment, same packing as the register
  typedef struct packed {
    logic        [PIX_W-1:0] minpx;
    logic        [PIX_W-1:0] maxpx;
    logic signed [VAL_W-1:0] minval;
    logic signed [VAL_W-1:0] maxval;
  } seg_t;

  // Classified item handed from the front end to the back end
  typedef struct packed {
    logic                    is_div;  // pixel still needs num / adr
    logic        [PIX_W-1:0] pixel;   // final pixel when not dividing
    logic                    clip;
    logic signed [NUM_W-1:0] num;
    logic        [ADR_W-1:0] adr;
  } mid_t;

  // One result item
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             clip;
  } res_t;

endpackage

[rtl/plc_fifo.sv]
// ----------------------------------------------------------------------------
// plc_fifo: small show-ahead queue
// Register array with read and write pointers and an occupancy count; the
// head entry is visible on rdata while empty is low.
// ----------------------------------------------------------------------------
module plc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic             do_push;
  logic             do_pop;

  assign do_push = push && (count != FULL_CNT);
  assign do_pop  = pop && (count != '0);
  assign empty   = (count == '0);
  assign rdata   = mem[rptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  // Pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == LAST) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == LAST) ? '0 : rptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/plc_front.sv]
// ----------------------------------------------------------------------------
// plc_front: segment select and classify
// Three register stages: pick the segment, form width/offset/slope terms,
// multiply. The sum of the products is written into the middle queue along
// with the pixel for items that need no division.
// ----------------------------------------------------------------------------
module plc_front #(
  parameter int MAX_SEGMENTS  = plc_pkg::MAX_SEGMENTS_DEF,
  parameter int FRACTION_BITS = plc_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_fire,
  input  logic signed [plc_pkg::VAL_W-1:0]    grid_value,
  input  logic                                value_missing,
  input  logic        [plc_pkg::CNT_W-1:0]    segment_count,
  input  plc_pkg::seg_t                       segs [MAX_SEGMENTS],
  output logic                                mid_push,
  output plc_pkg::mid_t                       mid_entry,
  output logic        [1:0]                   inflight
);

  localparam int VAL_W = plc_pkg::VAL_W;
  localparam int PIX_W = plc_pkg::PIX_W;
  localparam int CNT_W = plc_pkg::CNT_W;
  localparam int ADR_W = plc_pkg::ADR_W;
  localparam int NUM_W = plc_pkg::NUM_W;
  localparam int SEL_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int P1_W  = PIX_W + ADR_W;          // minpx * |width|
  localparam int P2_W  = (VAL_W + 1) + (PIX_W + 1); // offset * slope
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SEGMENTS);
  localparam logic [VAL_W-1:0] FRAC_MASK =
    VAL_W'((32'd1 << FRACTION_BITS) - 32'd1);

  // ---------------- stage A: segment select ----------------
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] sel;

  logic                    a_valid;
  logic signed [VAL_W-1:0] a_v;
  logic                    a_missing;
  logic                    a_none;
  logic [SEL_W-1:0]        a_sel;

  assign cnt = (segment_count > MAX_CNT) ? MAX_CNT : segment_count;

  // first segment in use whose upper value is not below the input,
  // falling back to the last segment in use
  always_comb begin
    sel = (cnt == '0) ? '0 : cnt - 1'b1;
    for (int k = MAX_SEGMENTS - 2; k >= 0; k--) begin
      if ((CNT_W'(k) + 1'b1 < cnt) && (grid_value <= segs[k].maxval)) begin
        sel = CNT_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    a_v       <= grid_value;
    a_missing <= value_missing;
    a_none    <= (cnt == '0);
    a_sel     <= sel[SEL_W-1:0];
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_fire;
    end
  end

  // ---------------- stage B: segment terms ----------------
  plc_pkg::seg_t           seg;
  logic signed [VAL_W:0]   dr;
  logic signed [VAL_W:0]   dr_abs;
  logic signed [VAL_W:0]   diff;
  logic signed [PIX_W:0]   dpx;
  logic signed [PIX_W:0]   dpx_adj;
  logic signed [VAL_W-1:0] trunc;
  logic                    trunc_up;
  logic        [PIX_W-1:0] dir_pixel;
  logic                    dir_clip;
  logic                    is_div;

  logic                    b_valid;
  logic                    b_div;
  logic        [PIX_W-1:0] b_pixel;
  logic                    b_clip;
  logic        [ADR_W-1:0] b_adr;
  logic        [PIX_W-1:0] b_minpx;
  logic signed [VAL_W:0]   b_diff;
  logic signed [PIX_W:0]   b_dpx;

  assign seg    = segs[a_sel];
  assign dr     = {seg.maxval[VAL_W-1], seg.maxval} - {seg.minval[VAL_W-1], seg.minval};
  assign dr_abs = dr[VAL_W] ? -dr : dr;
  assign diff   = {a_v[VAL_W-1], a_v} - {seg.minval[VAL_W-1], seg.minval};
  assign dpx    = $signed({1'b0, seg.maxpx}) - $signed({1'b0, seg.minpx});
  // a negative width flips the sign of the whole fraction; fold it into
  // the slope so the divisor stays positive
  assign dpx_adj = dr[VAL_W] ? -dpx : dpx;

  // truncation toward zero with no segments in use
  assign trunc_up = a_v[VAL_W-1] && ((a_v & FRAC_MASK) != '0);
  assign trunc    = (a_v >>> FRACTION_BITS) + $signed({{(VAL_W-1){1'b0}}, trunc_up});

  // items whose pixel is known without division
  always_comb begin
    dir_pixel = '0;
    dir_clip  = 1'b0;
    is_div    = 1'b0;
    if (a_missing) begin
      dir_pixel = '0;
    end else if (a_none) begin
      if (trunc < 0) begin
        dir_clip = 1'b1;
      end else if (trunc > $signed(VAL_W'(255))) begin
        dir_pixel = '1;
        dir_clip  = 1'b1;
      end else begin
        dir_pixel = trunc[PIX_W-1:0];
      end
    end else if (dr == '0) begin
      dir_pixel = seg.minpx;
    end else begin
      is_div = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    b_div   <= is_div;
    b_pixel <= dir_pixel;
    b_clip  <= dir_clip;
    b_adr   <= dr_abs[ADR_W-1:0];
    b_minpx <= seg.minpx;
    b_diff  <= diff;
    b_dpx   <= dpx_adj;
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
  end

  // ---------------- stage C: products ----------------
  logic        [P1_W-1:0] p1;
  logic signed [P2_W-1:0] p2;

  logic                    c_valid;
  logic                    c_div;
  logic        [PIX_W-1:0] c_pixel;
  logic                    c_clip;
  logic        [ADR_W-1:0] c_adr;
  logic        [P1_W-1:0]  c_p1;
  logic signed [P2_W-1:0]  c_p2;

  assign p1 = b_minpx * b_adr;
  assign p2 = b_diff * b_dpx;

  always_ff @(posedge clk) begin
    c_div   <= b_div;
    c_pixel <= b_pixel;
    c_clip  <= b_clip;
    c_adr   <= b_adr;
    c_p1    <= p1;
    c_p2    <= p2;
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= b_valid;
    end
  end

  // ---------------- queue write: numerator ----------------
  always_comb begin
    mid_entry.is_div = c_div;
    mid_entry.pixel  = c_pixel;
    mid_entry.clip   = c_clip;
    mid_entry.adr    = c_adr;
    mid_entry.num    = $signed({{(NUM_W-P1_W){1'b0}}, c_p1})
                     + $signed({{(NUM_W-P2_W){c_p2[P2_W-1]}}, c_p2});
  end

  assign mid_push = c_valid;
  assign inflight = {1'b0, a_valid} + {1'b0, b_valid} + {1'b0, c_valid};

endmodule

[rtl/plc_back.sv]
// ----------------------------------------------------------------------------
// plc_back: range check and pipelined divide
// Takes classified items from the middle queue while the result queue has
// room for everything in flight, sorts out saturated results, then runs an
// eight-stage restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module plc_back (
  input  logic                                    clk,
  input  logic                                    rst,
  input  plc_pkg::mid_t                           head,
  input  logic                                    mid_empty,
  output logic                                    mid_pop,
  input  logic [$clog2(plc_pkg::OUT_DEPTH+1)-1:0] out_count,
  output logic                                    out_push,
  output plc_pkg::res_t                           out_res
);

  localparam int PIX_W  = plc_pkg::PIX_W;
  localparam int ADR_W  = plc_pkg::ADR_W;
  localparam int NUM_W  = plc_pkg::NUM_W;
  localparam int REM_W  = plc_pkg::REM_W;
  localparam int STEPS  = PIX_W;
  localparam int STAGES = STEPS + 1;
  localparam int FL_W   = $clog2(STAGES + 1);
  localparam int OC_W   = $clog2(plc_pkg::OUT_DEPTH + 1);
  localparam int SUM_W  = ((FL_W > OC_W) ? FL_W : OC_W) + 1;

  typedef struct packed {
    logic             valid;
    logic             div;
    logic [PIX_W-1:0] pixel;
    logic             clip;
    logic [REM_W-1:0] rem;
    logic [ADR_W-1:0] adr;
    logic [PIX_W-1:0] q;
  } bk_t;

  bk_t             st [STAGES];
  bk_t             cls;
  logic [FL_W-1:0] inflight;
  logic signed [NUM_W-1:0] neg_sum;

  // items in flight across the divider
  always_comb begin
    inflight = '0;
    for (int s = 0; s < STAGES; s++) begin
      inflight = inflight + FL_W'(st[s].valid);
    end
  end

  // take a new item only when the result queue can absorb it
  assign mid_pop = !mid_empty &&
                   ((SUM_W'(inflight) + SUM_W'(out_count)) < SUM_W'(plc_pkg::OUT_DEPTH));

  // range check: quotient below zero, at or above 256, or a plain divide
  assign neg_sum = head.num + $signed({{(NUM_W-ADR_W){1'b0}}, head.adr});

  always_comb begin
    cls.valid = mid_pop;
    cls.div   = 1'b0;
    cls.pixel = head.pixel;
    cls.clip  = head.clip;
    cls.rem   = head.num[REM_W-1:0];
    cls.adr   = head.adr;
    cls.q     = '0;
    if (head.is_div) begin
      if (head.num < 0) begin
        // truncation toward zero: a small negative fraction still gives zero
        cls.pixel = '0;
        cls.clip  = (neg_sum <= 0);
      end else if ($unsigned(head.num) >= NUM_W'({head.adr, {PIX_W{1'b0}}})) begin
        cls.pixel = '1;
        cls.clip  = 1'b1;
      end else begin
        cls.div   = 1'b1;
        cls.clip  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st[0].valid <= 1'b0;
    end else begin
      st[0] <= cls;
    end
  end

  // one restoring step per stage, quotient MSB first
  for (genvar s = 1; s < STAGES; s++) begin : g_step
    localparam int BIT = STEPS - s;
    logic [REM_W-1:0] trial;
    bk_t              nxt;

    assign trial = REM_W'(st[s-1].adr) << BIT;

    always_comb begin
      nxt = st[s-1];
      if (st[s-1].div && (st[s-1].rem >= trial)) begin
        nxt.rem    = st[s-1].rem - trial;
        nxt.q[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st[s].valid <= 1'b0;
      end else begin
        st[s] <= nxt;
      end
    end
  end

  // result
  assign out_push      = st[STAGES-1].valid;
  assign out_res.pixel = st[STAGES-1].div ? st[STAGES-1].q : st[STAGES-1].pixel;
  assign out_res.clip  = st[STAGES-1].clip;

endmodule

[rtl/piecewise_linear_calibration.sv]
// ----------------------------------------------------------------------------
// piecewise_linear_calibration: grid value to pixel byte through a table of
// linear segments
//
//   channel   transfer when          payload
//   --------  ---------------------  ---------------------------------
//   input     push  && !full         grid_value, value_missing
//   result    pop   && !empty        pixel, clipped
//   config    cfg_we                 cfg_index, cfg_data
//
// One item per cycle sustained while full is low and the result queue drains. On
// its way to the ports an input passes three front stages, the middle queue, a
// range check and an eight-stage divider producing one quotient bit per stage.
// Reset clears the configuration registers and both queues at once.
// full rises when the front stages plus the middle queue hold 8 items; the
// divider stops taking items when the result queue could not absorb them.
// ----------------------------------------------------------------------------
module piecewise_linear_calibration #(
  parameter int MAX_SEGMENTS  = plc_pkg::MAX_SEGMENTS_DEF,
  parameter int FRACTION_BITS = plc_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // input channel
  input  logic                                push,
  output logic                                full,
  input  logic signed [plc_pkg::VAL_W-1:0]    grid_value,
  input  logic                                value_missing,
  // result channel
  output logic                                empty,
  input  logic                                pop,
  output logic        [plc_pkg::PIX_W-1:0]    pixel,
  output logic                                clipped,
  // configuration
  input  logic                                cfg_we,
  input  logic        [plc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [plc_pkg::CFG_W-1:0]    cfg_data
);

  localparam int MID_CW = $clog2(plc_pkg::MID_DEPTH + 1);
  localparam int OUT_CW = $clog2(plc_pkg::OUT_DEPTH + 1);
  localparam int MID_W  = $bits(plc_pkg::mid_t);
  localparam int RES_W  = $bits(plc_pkg::res_t);

  // ---------------- configuration registers ----------------
  logic [plc_pkg::CNT_W-1:0] segment_count;
  plc_pkg::seg_t             segs [MAX_SEGMENTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_count <= '0;
      for (int k = 0; k < MAX_SEGMENTS; k++) begin
        segs[k] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == plc_pkg::REG_SEGMENT_COUNT) begin
        segment_count <= cfg_data[plc_pkg::CNT_W-1:0];
      end
      // segments beyond the table size are never used and not stored
      for (int k = 0; k < MAX_SEGMENTS; k++) begin
        if (cfg_index == plc_pkg::REG_SEGMENT_0 + plc_pkg::CFG_IDX_W'(k)) begin
          segs[k] <= plc_pkg::seg_t'(cfg_data);
        end
      end
    end
  end

  // ---------------- front end ----------------
  logic                in_fire;
  logic                mid_push;
  plc_pkg::mid_t       mid_entry;
  logic [1:0]          front_inflight;
  logic [MID_CW-1:0]   mid_count;

  // credit check: room in the middle queue for every item in the front
  assign full    = ((MID_CW + 1)'(front_inflight) + (MID_CW + 1)'(mid_count))
                   >= (MID_CW + 1)'(plc_pkg::MID_DEPTH);
  assign in_fire = push && !full;

  plc_front #(
    .MAX_SEGMENTS  (MAX_SEGMENTS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_fire       (in_fire),
    .grid_value    (grid_value),
    .value_missing (value_missing),
    .segment_count (segment_count),
    .segs          (segs),
    .mid_push      (mid_push),
    .mid_entry     (mid_entry),
    .inflight      (front_inflight)
  );

  // ---------------- middle queue ----------------
  logic [MID_W-1:0] mid_rdata;
  logic             mid_empty;
  logic             mid_pop;

  plc_fifo #(
    .WIDTH (MID_W),
    .DEPTH (plc_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .wdata (mid_entry),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty),
    .count (mid_count)
  );

  // ---------------- back end ----------------
  logic              out_push;
  plc_pkg::res_t     out_res;
  logic [OUT_CW-1:0] out_count;

  plc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (plc_pkg::mid_t'(mid_rdata)),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .out_count (out_count),
    .out_push  (out_push),
    .out_res   (out_res)
  );

  // ---------------- result queue ----------------
  logic [RES_W-1:0] out_rdata;
  plc_pkg::res_t    head_res;

  plc_fifo #(
    .WIDTH (RES_W),
    .DEPTH (plc_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_res),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty),
    .count (out_count)
  );

  assign head_res = plc_pkg::res_t'(out_rdata);
  assign pixel    = head_res.pixel;
  assign clipped  = head_res.clip;

endmodule

[rtl/plc_checker.sv]
// ----------------------------------------------------------------------------
// plc_checker: port-level checks for the calibration block
// Watches the result channel and the flow control after reset; attached to
// the top level by the bind below.
// ----------------------------------------------------------------------------
module plc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          full,
  input logic                          empty,
  input logic                          pop,
  input logic [plc_pkg::PIX_W-1:0]     pixel,
  input logic                          clipped
);

  // reset leaves both queues drained and the input open
  a_reset_state: assert property (@(posedge clk)
    rst |=> empty && !full)
    else $error("queues not cleared by reset");

  // a waiting result holds until it is taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(pixel) && $stable(clipped))
    else $error("waiting result changed before transfer");

  // saturation only ever lands on the ends of the pixel range
  a_clip_range: assert property (@(posedge clk) disable iff (rst)
    !empty && clipped |-> (pixel == '0) || (pixel == '1))
    else $error("clipped result not at 0 or 255");

endmodule

bind piecewise_linear_calibration plc_checker u_checker (.*);

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: piecewise linear calibration
// Streams grid values through the queue-style input and checks every pixel
// byte and clip flag against typed-in values or a local model of the segment
// table. A short table of directed values runs first. Then random calibration
// tables run, with part of the values aimed at the segments in use. Both sides
// idle at random, and one long pop hold-off backs up the input.
// ----------------------------------------------------------------------------
module testbench;
  import plc_pkg::*;

  localparam int CAL_PHASES  = 10;
  localparam int PHASE_ITEMS = 200;
  localparam int LATENCY_PAD = 40;
  localparam int HOLD_AFTER  = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int SHOW_LIMIT  = 10;

  // calibration set a directed row runs under
  localparam logic [1:0] SET_RESET = 2'd0;
  localparam logic [1:0] SET_TABLE = 2'd1;

  typedef struct packed {
    logic [1:0]       cfg_set;
    logic [VAL_W-1:0] value;
    logic             missing;
    logic             known;    // want is typed in, not predicted
    res_t             want;
  } stim_row_t;

  logic                    clk           = 1'b0;
  logic                    rst           = 1'b1;
  logic                    push          = 1'b0;
  logic                    full;
  logic signed [VAL_W-1:0] grid_value    = '0;
  logic                    value_missing = 1'b0;
  logic                    empty;
  logic                    pop           = 1'b0;
  logic [PIX_W-1:0]        pixel;
  logic                    clipped;
  logic                    cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index     = '0;
  logic [CFG_W-1:0]        cfg_data      = '0;

  // shadow of the calibration registers, and the next setting to load
  logic [CNT_W-1:0] cal_count;
  seg_t             cal_table [SEG_REGS];
  logic [CNT_W-1:0] next_count;
  seg_t             next_table [SEG_REGS];

  res_t        expected_pixels [$];
  stim_row_t   directed_rows [$];
  int unsigned mismatch_count = 0;
  int unsigned results_seen   = 0;
  bit          calm           = 1'b0;  // no idling on either side

  piecewise_linear_calibration dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .grid_value    (grid_value),
    .value_missing (value_missing),
    .empty         (empty),
    .pop           (pop),
    .pixel         (pixel),
    .clipped       (clipped),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit roll_idle();
    return !calm && ($urandom_range(99) < 7);
  endfunction

  // Pixel byte for one value under the shadow table
  function automatic res_t map_to_pixel(input logic signed [VAL_W-1:0] v, input logic m);
    res_t   r;
    seg_t   s;
    longint val, lo, hi, dr, num, q;
    int     n, used;
    r = '0;
    if (m) return r;
    val  = longint'(v);
    used = int'(cal_count);
    if (used > MAX_SEGMENTS_DEF) used = MAX_SEGMENTS_DEF;
    if (used == 0) begin
      q = val / (longint'(1) << FRACTION_BITS_DEF);
    end else begin
      // first segment whose upper value is not below v, else the last one
      n = 0;
      while (n < used - 1 && val > longint'($signed(cal_table[n].maxval))) n++;
      s  = cal_table[n];
      lo = longint'(s.minval);
      hi = longint'(s.maxval);
      dr = hi - lo;
      if (dr == 0) begin
        q = longint'(s.minpx);
      end else begin
        num = longint'(s.minpx) * dr
            + (val - lo) * (longint'(s.maxpx) - longint'(s.minpx));
        if (dr < 0) begin
          dr  = -dr;
          num = -num;
        end
        q = num / dr;
      end
    end
    // saturate to a byte
    if (q < 0) begin
      r.pixel = '0;
      r.clip  = 1'b1;
    end else if (q > 255) begin
      r.pixel = '1;
      r.clip  = 1'b1;
    end else begin
      r.pixel = q[PIX_W-1:0];
      r.clip  = 1'b0;
    end
    return r;
  endfunction

  function automatic void add_row(input logic [1:0] set, input logic [VAL_W-1:0] value,
                                  input logic missing, input logic known,
                                  input logic [PIX_W-1:0] px, input logic clip);
    stim_row_t row;
    row.cfg_set    = set;
    row.value      = value;
    row.missing    = missing;
    row.known      = known;
    row.want.pixel = px;
    row.want.clip  = clip;
    directed_rows.push_back(row);
  endfunction

  task automatic flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= SHOW_LIMIT) $display("%0t: %s", $time, msg);
  endtask

  // One input transfer; the expectation is queued at the accepting edge
  task automatic send_item(input logic signed [VAL_W-1:0] v, input logic m,
                           input logic known, input res_t want);
    while (roll_idle()) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push          <= 1'b1;
    grid_value    <= v;
    value_missing <= m;
    do @(posedge clk); while (full);
    expected_pixels.push_back(known ? want : map_to_pixel(v, m));
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  // Write all eight registers back to back, then update the shadow copy
  task automatic load_registers();
    for (int i = 0; i <= SEG_REGS; i++) begin
      cfg_we <= 1'b1;
      if (i == 0) begin
        cfg_index <= REG_SEGMENT_COUNT;
        cfg_data  <= CFG_W'(next_count);
      end else begin
        cfg_index <= REG_SEGMENT_0 + CFG_IDX_W'(i - 1);
        cfg_data  <= next_table[i-1];
      end
      @(posedge clk);
    end
    cfg_we    <= 1'b0;
    cal_count  = next_count;
    cal_table  = next_table;
  endtask

  // Result side: check each transfer, idle at random, one long hold-off
  initial begin : result_side
    int unsigned hold_left;
    bit          hold_done;
    res_t        want;
    hold_left = 0;
    hold_done = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        results_seen++;
        if (expected_pixels.size() == 0) begin
          flag_error($sformatf("unexpected result: pixel %0d clipped %0b", pixel, clipped));
        end else begin
          want = expected_pixels.pop_front();
          if (pixel !== want.pixel || clipped !== want.clip)
            flag_error($sformatf("pixel %0d clipped %0b, expected pixel %0d clipped %0b",
                                 pixel, clipped, want.pixel, want.clip));
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        pop <= 1'b0;
      end else begin
        pop <= !roll_idle();
      end
    end
  end

  initial begin : stimulus
    logic [1:0]              cur_set;
    logic signed [VAL_W-1:0] v;
    logic                    m;
    int                      bound [8];
    int                      a, b, lo, hi;
    int unsigned             r, j;

    cal_count = '0;
    for (int i = 0; i < SEG_REGS; i++) cal_table[i] = '0;

    // Reset table: plain truncation toward zero, expectations typed in
    add_row(SET_RESET, 16'h8000, 1'b0, 1'b1, 8'd0,   1'b1);  // most negative
    add_row(SET_RESET, 16'h7FFF, 1'b0, 1'b1, 8'd255, 1'b1);  // most positive
    add_row(SET_RESET, 16'h0000, 1'b0, 1'b1, 8'd0,   1'b0);
    add_row(SET_RESET, 16'h000F, 1'b0, 1'b1, 8'd0,   1'b0);  // fraction dropped
    add_row(SET_RESET, 16'hFFF1, 1'b0, 1'b1, 8'd0,   1'b0);  // truncates up to zero
    add_row(SET_RESET, 16'hFFF0, 1'b0, 1'b1, 8'd0,   1'b1);  // -1.0 saturates low
    add_row(SET_RESET, 16'h0FF0, 1'b0, 1'b1, 8'd255, 1'b0);  // 255.0 fits
    add_row(SET_RESET, 16'h1000, 1'b0, 1'b1, 8'd255, 1'b1);  // 256.0 saturates high
    add_row(SET_RESET, 16'h7FFF, 1'b1, 1'b1, 8'd0,   1'b0);  // missing value
    // Three segments: rising, zero width, falling; values on and past each edge
    add_row(SET_TABLE, 16'h8000, 1'b0, 1'b0, 8'd0,   1'b0);
    add_row(SET_TABLE, 16'hF9C0, 1'b0, 1'b0, 8'd0,   1'b0);
    add_row(SET_TABLE, 16'hFCE0, 1'b0, 1'b0, 8'd0,   1'b0);
    add_row(SET_TABLE, 16'h0000, 1'b0, 1'b0, 8'd0,   1'b0);
    add_row(SET_TABLE, 16'h0001, 1'b0, 1'b0, 8'd0,   1'b0);
    add_row(SET_TABLE, 16'h0100, 1'b0, 1'b0, 8'd0,   1'b0);
    add_row(SET_TABLE, 16'h0101, 1'b0, 1'b0, 8'd0,   1'b0);
    add_row(SET_TABLE, 16'h0200, 1'b0, 1'b0, 8'd0,   1'b0);
    add_row(SET_TABLE, 16'h0201, 1'b0, 1'b0, 8'd0,   1'b0);  // above every upper value
    add_row(SET_TABLE, 16'h7FFF, 1'b0, 1'b0, 8'd0,   1'b0);
    add_row(SET_TABLE, 16'hFFFF, 1'b1, 1'b1, 8'd0,   1'b0);  // missing value

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part
    cur_set = SET_RESET;
    foreach (directed_rows[k]) begin
      if (directed_rows[k].cfg_set != cur_set) begin
        drain_results();
        next_count    = 3'd3;
        next_table[0] = {8'd0,   8'd100, 16'hF9C0, 16'h0000};
        next_table[1] = {8'd77,  8'd200, 16'h0100, 16'h0100};
        next_table[2] = {8'd255, 8'd0,   16'h1000, 16'h0200};
        for (int i = 3; i < SEG_REGS; i++) next_table[i] = '1;
        load_registers();
        cur_set = directed_rows[k].cfg_set;
      end
      send_item(directed_rows[k].value, directed_rows[k].missing,
                directed_rows[k].known, directed_rows[k].want);
    end

    // Random part: a new calibration table per phase
    for (int p = 0; p < CAL_PHASES; p++) begin
      drain_results();
      // ascending breakpoints spread over the whole value range
      for (int k = 0; k < 8; k++) bound[k] = -32768 + k * 8192 + int'($urandom_range(8191));
      for (int i = 0; i < SEG_REGS; i++) begin
        r = $urandom_range(99);
        next_table[i].minpx  = PIX_W'($urandom());
        next_table[i].maxpx  = PIX_W'($urandom());
        next_table[i].maxval = VAL_W'(bound[i+1]);
        if (r < 10)      next_table[i].minval = VAL_W'(bound[i+1]);  // zero width
        else if (r < 35) next_table[i].minval = VAL_W'($urandom());  // often falling
        else             next_table[i].minval = VAL_W'(bound[i]);
      end
      case (p)
        0: begin
          next_count = 3'd7;
          for (int i = 0; i < SEG_REGS; i++) next_table[i] = '1;
        end
        1:       next_count = 3'd0;
        2:       next_count = 3'd7;
        3:       next_count = 3'd1;
        default: next_count = CNT_W'($urandom_range(7));
      endcase
      load_registers();
      calm = (p == 5);

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(99);
        v = VAL_W'($urandom());
        m = (r < 8);
        if (r >= 8 && r < 60) begin
          if (cal_count == 0) begin
            // mostly lands inside the byte range after truncation
            v = VAL_W'(-256 + int'($urandom_range(4608)));
          end else begin
            // around one segment in use
            j  = $urandom_range(cal_count - 1);
            a  = int'(cal_table[j].minval);
            b  = int'(cal_table[j].maxval);
            lo = ((a < b) ? a : b) - 32;
            hi = ((a < b) ? b : a) + 32;
            if (lo < -32768) lo = -32768;
            if (hi > 32767) hi = 32767;
            v = VAL_W'(lo + int'($urandom_range(hi - lo)));
          end
        end
        send_item(v, m, 1'b0, '0);
      end
    end

    calm = 1'b0;
    drain_results();
    repeat (LATENCY_PAD) @(posedge clk);
    if (mismatch_count == 0 && expected_pixels.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
